FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rbc_pkg.sv
// Shared widths, types, register indexes and reset coefficients of the resonant biquad.
package rbc_pkg;

    // Field widths.
    localparam int ERROR_WIDTH    = 24;
    localparam int OUT_WIDTH      = 32;
    localparam int COEF_FRAC_BITS = 29;
    localparam int COEF_W         = 32;

    // Product and accumulator widths.
    localparam int P_ERR_W = COEF_W + ERROR_WIDTH;
    localparam int P_OUT_W = COEF_W + OUT_WIDTH;
    localparam int MAX_P_W = (P_ERR_W > P_OUT_W) ? P_ERR_W : P_OUT_W;
    localparam int ACC_W   = MAX_P_W + 2;

    // Stream widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = ((ERROR_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_WIDTH + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_A0 = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_A2 = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_B1 = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_B2 = CFG_INDEX_W'(3);

    // Item kinds carried on the input tuser bit.
    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    // Reset coefficients held in Q2.30.
    localparam logic signed [63:0] A0_Q30 = 64'sd644200084;
    localparam logic signed [63:0] A2_Q30 = -64'sd644200084;
    localparam logic signed [63:0] B1_Q30 = -64'sd2147312422;
    localparam logic signed [63:0] B2_Q30 = 64'sd1073612984;
    localparam int COEF_SHIFT = 30 - COEF_FRAC_BITS;

    typedef struct packed {
        logic signed [COEF_W-1:0] a0;
        logic signed [COEF_W-1:0] a2;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
    } coef_set_t;

    typedef struct packed {
        logic signed [ERROR_WIDTH-1:0] err_prev;
        logic signed [ERROR_WIDTH-1:0] err_prev2;
        logic signed [OUT_WIDTH-1:0]   out_prev;
        logic signed [OUT_WIDTH-1:0]   out_prev2;
    } hist_t;

    // Round a Q2.30 value half up to the configured fraction width.
    function automatic logic signed [COEF_W-1:0] coef_reset(input logic signed [63:0] q30);
        logic signed [63:0] r;
        r = q30;
        if (COEF_SHIFT > 0)
        begin
            r = (q30 + (64'sd1 <<< (COEF_SHIFT - 1))) >>> COEF_SHIFT;
        end
        return r[COEF_W-1:0];
    endfunction

endpackage

FILE: sv/rbc_coef_regs.sv
// Coefficient register file written through the configuration channel.
module rbc_coef_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [rbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rbc_pkg::COEF_W-1:0]         cfg_data,
    output logic                               cfg_ready,
    output rbc_pkg::coef_set_t                 coef
);

    rbc_pkg::coef_set_t coef_reg;
    rbc_pkg::coef_set_t coef_next;

    // Writes are always taken; an index beyond the list is dropped.
    assign cfg_ready = 1'b1;
    assign coef      = coef_reg;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                rbc_pkg::REG_A0: coef_next.a0 = cfg_data;
                rbc_pkg::REG_A2: coef_next.a2 = cfg_data;
                rbc_pkg::REG_B1: coef_next.b1 = cfg_data;
                rbc_pkg::REG_B2: coef_next.b2 = cfg_data;
                default:         coef_next    = coef_reg;
            endcase
        end
    end

    // Reset loads the Tustin coefficients.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.a0 <= rbc_pkg::coef_reset(rbc_pkg::A0_Q30);
            coef_reg.a2 <= rbc_pkg::coef_reset(rbc_pkg::A2_Q30);
            coef_reg.b1 <= rbc_pkg::coef_reset(rbc_pkg::B1_Q30);
            coef_reg.b2 <= rbc_pkg::coef_reset(rbc_pkg::B2_Q30);
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

endmodule

FILE: sv/rbc_mac.sv
// Four parallel products, exact sum, arithmetic shift and saturation of one update.
module rbc_mac
(
    input  rbc_pkg::coef_set_t                        coef,
    input  rbc_pkg::hist_t                            hist,
    input  logic signed [rbc_pkg::ERROR_WIDTH-1:0]    err,
    output logic signed [rbc_pkg::OUT_WIDTH-1:0]      drive,
    output logic                                      saturated
);

    localparam int P_ERR_W = rbc_pkg::P_ERR_W;
    localparam int P_OUT_W = rbc_pkg::P_OUT_W;
    localparam int ACC_W   = rbc_pkg::ACC_W;
    localparam int OUT_W   = rbc_pkg::OUT_WIDTH;

    logic signed [P_ERR_W-1:0] p_a0;
    logic signed [P_ERR_W-1:0] p_a2;
    logic signed [P_OUT_W-1:0] p_b1;
    logic signed [P_OUT_W-1:0] p_b2;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   shifted;
    logic [ACC_W-OUT_W:0]      top_bits;

    // Exact products at their natural widths.
    assign p_a0 = coef.a0 * err;
    assign p_a2 = coef.a2 * hist.err_prev2;
    assign p_b1 = coef.b1 * hist.out_prev;
    assign p_b2 = coef.b2 * hist.out_prev2;

    // Sign-extended sum; feedback terms are subtracted.
    assign acc = {{(ACC_W - P_ERR_W){p_a0[P_ERR_W-1]}}, p_a0}
               + {{(ACC_W - P_ERR_W){p_a2[P_ERR_W-1]}}, p_a2}
               - {{(ACC_W - P_OUT_W){p_b1[P_OUT_W-1]}}, p_b1}
               - {{(ACC_W - P_OUT_W){p_b2[P_OUT_W-1]}}, p_b2};

    assign shifted  = acc >>> rbc_pkg::COEF_FRAC_BITS;
    assign top_bits = shifted[ACC_W-1:OUT_W-1];

    // The value fits when every bit from the output sign upward agrees.
    always_comb
    begin
        if ((&top_bits) || !(|top_bits))
        begin
            drive     = shifted[OUT_W-1:0];
            saturated = 1'b0;
        end
        else if (shifted[ACC_W-1])
        begin
            drive     = {1'b1, {(OUT_W - 1){1'b0}}};
            saturated = 1'b1;
        end
        else
        begin
            drive     = {1'b0, {(OUT_W - 1){1'b1}}};
            saturated = 1'b1;
        end
    end

endmodule

FILE: sv/resonant_biquad_controller.sv
// Top level of the resonant biquad controller: stream ports, history and result registers.
// The block takes one beat per clock while the output is not stalled and returns one result
// beat per input beat, in order. Each beat passes an input register and a result register
// before its result beat is presented, and it leaves when the output is not stalled. The output
// recursion is combinational: the four coefficient multipliers, the exact sum, the shift by
// the coefficient fraction width and the saturation all sit between the input register and
// the history registers. A beat with tuser set clears the error and output histories and
// returns zero. Coefficients must be written on the configuration channel only while no beat
// is in flight; the block itself does not enforce this.
module resonant_biquad_controller
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [rbc_pkg::IN_TDATA_W-1:0]       s_tdata,   // [ERROR_WIDTH-1:0] error_sample
    input  logic [0:0]                           s_tuser,   // [0] action
    // Output stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [rbc_pkg::OUT_TDATA_W-1:0]      m_tdata,   // [OUT_WIDTH-1:0] drive
    output logic [0:0]                           m_tuser,   // [0] saturated
    // Configuration writes.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rbc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [rbc_pkg::COEF_W-1:0]           cfg_data
);

    localparam int ERR_W = rbc_pkg::ERROR_WIDTH;
    localparam int OUT_W = rbc_pkg::OUT_WIDTH;

    rbc_pkg::coef_set_t          coef;
    rbc_pkg::hist_t              hist_reg;
    rbc_pkg::hist_t              hist_next;

    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic                        in_action_reg;
    logic signed [ERR_W-1:0]     in_err_reg;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic signed [OUT_W-1:0]     out_drive_reg;
    logic                        out_sat_reg;

    logic signed [OUT_W-1:0]     mac_drive;
    logic                        mac_sat;
    logic                        out_take;
    logic                        proc;
    logic                        in_fire;

    rbc_coef_regs u_coef
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .coef      (coef)
    );

    rbc_mac u_mac
    (
        .coef      (coef),
        .hist      (hist_reg),
        .err       (in_err_reg),
        .drive     (mac_drive),
        .saturated (mac_sat)
    );

    // Handshake: the result register frees up when empty or drained this cycle.
    assign out_take = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && out_take;
    assign s_tready = !in_valid_reg || out_take;
    assign in_fire  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(rbc_pkg::OUT_TDATA_W - OUT_W){1'b0}}, out_drive_reg};
    assign m_tuser  = out_sat_reg;

    // Valid flags and history update.
    always_comb
    begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = out_take ? in_valid_reg : out_valid_reg;
        hist_next      = hist_reg;
        if (proc)
        begin
            if (in_action_reg == rbc_pkg::ACT_CLEAR)
            begin
                hist_next = '0;
            end
            else
            begin
                hist_next.err_prev2 = hist_reg.err_prev;
                hist_next.err_prev  = in_err_reg;
                hist_next.out_prev2 = hist_reg.out_prev;
                hist_next.out_prev  = mac_drive;
            end
        end
    end

    // Control and history state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hist_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            hist_reg      <= hist_next;
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_action_reg <= s_tuser[0];
            in_err_reg    <= s_tdata[ERR_W-1:0];
        end
    end

    // Result payload register; a clear beat returns zero.
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            if (in_action_reg == rbc_pkg::ACT_CLEAR)
            begin
                out_drive_reg <= '0;
                out_sat_reg   <= 1'b0;
            end
            else
            begin
                out_drive_reg <= mac_drive;
                out_sat_reg   <= mac_sat;
            end
        end
    end

endmodule

FILE: sv/rbc_checker.sv
// Port-level checks of the resonant biquad controller and their binding to the top level.
`include "assert_macros.svh"

module rbc_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [rbc_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input logic [0:0]                           m_tuser
);

    localparam int OUT_W = rbc_pkg::OUT_WIDTH;

    logic is_min;
    logic is_max;

    assign is_min = (m_tdata[OUT_W-1:0] == {1'b1, {(OUT_W - 1){1'b0}}});
    assign is_max = (m_tdata[OUT_W-1:0] == {1'b0, {(OUT_W - 1){1'b1}}});

    // Input is only held off while a result waits on a stalled output.
    `ASSERT_SAME(a_stall_only_on_backpressure, clk, rst_n, !s_tready, m_tvalid && !m_tready, "input stalled without output backpressure")

    // A flagged result is clipped to one end of the output range.
    `ASSERT_SAME(a_sat_at_limit, clk, rst_n, m_tvalid && m_tuser[0], is_min || is_max, "saturation flag on an unclipped value")

    // A stalled result beat keeps its value.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // An idle block with no input pending accepts at once.
    `ASSERT_NEXT(a_ready_when_idle, clk, rst_n, !m_tvalid && !s_tvalid, s_tready, "empty block not ready")

endmodule

bind resonant_biquad_controller rbc_checker u_rbc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/testbench.sv
// Self-checking testbench for the resonant biquad controller stream block.
`timescale 1ns / 100ps

module testbench;

    localparam int ERR_W       = rbc_pkg::ERROR_WIDTH;
    localparam int OUT_W       = rbc_pkg::OUT_WIDTH;
    localparam int COEF_W      = rbc_pkg::COEF_W;
    localparam int IDX_W       = rbc_pkg::CFG_INDEX_W;
    localparam int FRAC_BITS   = rbc_pkg::COEF_FRAC_BITS;

    localparam int PIPE_LATENCY   = 2;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 50;

    // An index that names no coefficient; the block must ignore writes to it.
    localparam logic [IDX_W-1:0] REG_NONE = 8'hFF;

    // Coefficient values the block holds after reset (Q3.29).
    localparam logic signed [COEF_W-1:0] A0_RESET = 32'sd322100042;
    localparam logic signed [COEF_W-1:0] A2_RESET = -32'sd322100042;
    localparam logic signed [COEF_W-1:0] B1_RESET = -32'sd1073656211;
    localparam logic signed [COEF_W-1:0] B2_RESET = 32'sd536806492;
    localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;

    localparam logic signed [ERR_W-1:0] SAMPLE_MAX = 24'sh7F_FFFF;
    localparam logic signed [ERR_W-1:0] SAMPLE_MIN = 24'sh80_0000;

    // Clipping bounds of the drive output, at accumulator width.
    localparam logic signed [127:0] DRIVE_MAX = (128'sd1 <<< (OUT_W - 1)) - 128'sd1;
    localparam logic signed [127:0] DRIVE_MIN = -DRIVE_MAX - 128'sd1;

    typedef enum {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

    typedef struct {
        logic signed [OUT_W-1:0] drive;
        logic                    saturated;
    } drive_result_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [rbc_pkg::IN_TDATA_W-1:0]     s_tdata = '0;
    logic [0:0]                         s_tuser = rbc_pkg::ACT_UPDATE;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [rbc_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic [0:0]                         m_tuser;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [IDX_W-1:0]                   cfg_index = rbc_pkg::REG_A0;
    logic [COEF_W-1:0]                  cfg_data = '0;

    // Predictor state: coefficients and the four history registers.
    rbc_pkg::coef_set_t coefs;
    rbc_pkg::hist_t     hist;

    drive_result_t expected_drive_q[$];
    int            errors = 0;
    int            idle_cycles = 0;

    // Sender burst shaping and receiver stall control.
    bit            gaps_on = 1'b1;
    int            burst_left = 0;
    sink_mode_t    sink_mode = SINK_ALWAYS;
    logic [7:0]    stall_pattern = 8'b1011_0110;
    int            hold_cycles = 0;

    resonant_biquad_controller uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // One step of the resonator: exact sum, floor shift, clip, history shift; a clear zeroes history.
    function automatic drive_result_t resonator_step(input logic action,
                                                     input logic signed [ERR_W-1:0] sample);
        drive_result_t          r;
        logic signed [127:0]    acc;
        logic signed [127:0]    shifted;
        r.drive     = '0;
        r.saturated = 1'b0;
        if (action == rbc_pkg::ACT_CLEAR)
        begin
            hist = '0;
            return r;
        end
        acc = coefs.a0 * sample + coefs.a2 * hist.err_prev2
            - coefs.b1 * hist.out_prev - coefs.b2 * hist.out_prev2;
        shifted = acc >>> FRAC_BITS;
        if (shifted > DRIVE_MAX)
        begin
            shifted     = DRIVE_MAX;
            r.saturated = 1'b1;
        end
        else if (shifted < DRIVE_MIN)
        begin
            shifted     = DRIVE_MIN;
            r.saturated = 1'b1;
        end
        r.drive        = shifted[OUT_W-1:0];
        hist.err_prev2 = hist.err_prev;
        hist.err_prev  = sample;
        hist.out_prev2 = hist.out_prev;
        hist.out_prev  = r.drive;
        return r;
    endfunction

    // Error samples weighted toward the extremes and small values.
    function automatic logic signed [ERR_W-1:0] rand_sample();
        logic signed [ERR_W-1:0] s;
        case ($urandom_range(0, 9))
            0: s = SAMPLE_MAX;
            1: s = SAMPLE_MIN;
            2: s = ERR_W'($urandom_range(0, 511)) - 24'sd256;
            default: s = ERR_W'($urandom);
        endcase
        return s;
    endfunction

    // Send one beat on the input stream, with bursts and, when gaps are enabled, random gaps between them.
    task automatic send_item(input logic action, input logic signed [ERR_W-1:0] sample);
        int gap;
        @(negedge clk);
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tuser  <= action;
        do @(posedge clk); while (!s_tready);
        expected_drive_q.push_back(resonator_step(action, sample));
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (expected_drive_q.size() != 0) @(negedge clk);
        repeat (PIPE_LATENCY + 2) @(negedge clk);
    endtask

    // Write one coefficient register and mirror it in the predictor.
    task automatic write_coef(input logic [IDX_W-1:0] index, input logic [COEF_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            rbc_pkg::REG_A0: coefs.a0 = value;
            rbc_pkg::REG_A2: coefs.a2 = value;
            rbc_pkg::REG_B1: coefs.b1 = value;
            rbc_pkg::REG_B2: coefs.b2 = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_coefs(input rbc_pkg::coef_set_t c);
        drain_results();
        write_coef(rbc_pkg::REG_A0, c.a0);
        write_coef(rbc_pkg::REG_A2, c.a2);
        write_coef(rbc_pkg::REG_B1, c.b1);
        write_coef(rbc_pkg::REG_B2, c.b2);
    endtask

    // A full-scale impulse and single extreme samples through the reset coefficients.
    task automatic test_reset_state();
        send_item(rbc_pkg::ACT_UPDATE, SAMPLE_MAX);
        repeat (4) send_item(rbc_pkg::ACT_UPDATE, '0);
        send_item(rbc_pkg::ACT_UPDATE, SAMPLE_MIN);
        send_item(rbc_pkg::ACT_UPDATE, -24'sd1);
        send_item(rbc_pkg::ACT_UPDATE, 24'sd1);
    endtask

    // Clear returns zero, ignores its sample and restarts the history.
    task automatic test_clear();
        send_item(rbc_pkg::ACT_CLEAR, SAMPLE_MAX);
        send_item(rbc_pkg::ACT_UPDATE, SAMPLE_MAX);
        send_item(rbc_pkg::ACT_CLEAR, SAMPLE_MIN);
        send_item(rbc_pkg::ACT_UPDATE, 24'sd1);
    endtask

    // Unstable feedback drives the output into both clip limits.
    task automatic test_saturation();
        rbc_pkg::coef_set_t c;
        c = '{a0: COEF_MAX, a2: COEF_MIN, b1: COEF_MIN, b2: COEF_MAX};
        load_coefs(c);
        repeat (6) send_item(rbc_pkg::ACT_UPDATE, SAMPLE_MAX);
        send_item(rbc_pkg::ACT_CLEAR, '0);
        repeat (6) send_item(rbc_pkg::ACT_UPDATE, SAMPLE_MIN);
    endtask

    // All-max, all-min and zero coefficient sets, and a write to an unused index.
    task automatic test_config_extremes();
        rbc_pkg::coef_set_t c;
        c = '{a0: COEF_MAX, a2: COEF_MAX, b1: COEF_MAX, b2: COEF_MAX};
        load_coefs(c);
        repeat (8) send_item(rbc_pkg::ACT_UPDATE, rand_sample());
        c = '{a0: COEF_MIN, a2: COEF_MIN, b1: COEF_MIN, b2: COEF_MIN};
        load_coefs(c);
        repeat (8) send_item(rbc_pkg::ACT_UPDATE, rand_sample());
        c = '{default: '0};
        load_coefs(c);
        write_coef(REG_NONE, $urandom);
        repeat (4) send_item(rbc_pkg::ACT_UPDATE, rand_sample());
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        rbc_pkg::coef_set_t c;
        c = '{a0: A0_RESET, a2: A2_RESET, b1: B1_RESET, b2: B2_RESET};
        load_coefs(c);
        sink_mode   = SINK_ALWAYS;
        gaps_on     = 1'b0;
        hold_cycles = 150;
        repeat (40) send_item(rbc_pkg::ACT_UPDATE, rand_sample());
        gaps_on = 1'b1;
    endtask

    // Random phases, each with its own coefficients, stall style and sender shape.
    task automatic test_random_phases();
        rbc_pkg::coef_set_t c;
        int                 b2v;
        int                 b1mag;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 3))
                0: c = '{a0: A0_RESET, a2: A2_RESET, b1: B1_RESET, b2: B2_RESET};
                1, 2:
                begin
                    // Stable pole pair: |b2| < 1 and |b1| < 1 + b2.
                    b2v   = $urandom_range(0, (1 << 30) - 2) - ((1 << 29) - 1);
                    b1mag = $urandom_range(0, (1 << 29) + b2v - 1);
                    c.a0  = $urandom_range(0, 1 << 30) - (1 << 29);
                    c.a2  = $urandom_range(0, 1 << 30) - (1 << 29);
                    c.b1  = $urandom_range(0, 1) ? b1mag : -b1mag;
                    c.b2  = b2v;
                end
                default:
                begin
                    c.a0 = $urandom;
                    c.a2 = $urandom;
                    c.b1 = $urandom;
                    c.b2 = $urandom;
                end
            endcase
            load_coefs(c);
            if ($urandom_range(0, 2) == 0)
                write_coef(REG_NONE, $urandom);
            sink_mode     = sink_mode_t'($urandom_range(0, 2));
            stall_pattern = 8'($urandom_range(1, 255));
            gaps_on       = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1))
                send_item(rbc_pkg::ACT_CLEAR, rand_sample());
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_item(rbc_pkg::ACT_CLEAR, rand_sample());
                else
                    send_item(rbc_pkg::ACT_UPDATE, rand_sample());
            end
        end
    endtask

    task automatic finish_run();
        drain_results();
        repeat (PIPE_LATENCY + 6) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    endtask

    // Receiver readiness: a long hold when requested, otherwise the phase's stall style.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles--;
        end
        else
        begin
            case (sink_mode)
                SINK_ALWAYS: m_tready <= 1'b1;
                SINK_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    m_tready      <= stall_pattern[0];
                    stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
                end
            endcase
        end
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge clk)
    begin : check_drive
        drive_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_drive_q.size() == 0)
            begin
                $error("drive: no result expected, got %0d", $signed(m_tdata[OUT_W-1:0]));
                errors++;
            end
            else
            begin
                want = expected_drive_q.pop_front();
                if (m_tdata[OUT_W-1:0] !== want.drive)
                begin
                    $error("drive: expected %0d, actual %0d", want.drive,
                           $signed(m_tdata[OUT_W-1:0]));
                    errors++;
                end
                if (m_tuser[0] !== want.saturated)
                begin
                    $error("saturated: expected %0b, actual %0b", want.saturated, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // End the run if no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        coefs = '{a0: A0_RESET, a2: A2_RESET, b1: B1_RESET, b2: B2_RESET};
        hist  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_clear();
        test_saturation();
        test_config_extremes();
        test_backpressure();
        test_random_phases();
        finish_run();
    end

endmodule
